### rtl/core/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types and codes of the bitstream field reader.
// ----------------------------------------------------------------------------
package bfr_pkg;

    localparam int WORD_BITS = 32;

    // item kinds
    localparam logic [2:0] KIND_LOAD  = 3'd0;
    localparam logic [2:0] KIND_GET   = 3'd1;
    localparam logic [2:0] KIND_PEEK  = 3'd2;
    localparam logic [2:0] KIND_SKIP  = 3'd3;
    localparam logic [2:0] KIND_ALIGN = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_STARVED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // largest field that one beat may read
    localparam logic [5:0] MAX_FIELD = 6'd32;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

endpackage

### rtl/core/bfr_word_queue.sv
// ----------------------------------------------------------------------------
// bfr_word_queue
// Word queue with the two oldest words held in a register window and the
// rest in a memory whose read data is prefetched into a register.
// ----------------------------------------------------------------------------
module bfr_word_queue #(
    parameter int WORD_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bfr_pkg::queue_ctrl_t              ctrl,
    input  bfr_pkg::word_t                    load_word,
    output bfr_pkg::word_t                    head_word,
    output bfr_pkg::word_t                    next_word,
    output logic [$clog2(WORD_DEPTH+1)-1:0]   word_count
);
    import bfr_pkg::*;

    localparam int CW = $clog2(WORD_DEPTH + 1);
    localparam int AW = $clog2(WORD_DEPTH);

    word_t          mem [WORD_DEPTH];
    word_t          win0_reg;
    word_t          win1_reg;
    word_t          rd_data_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [AW-1:0]  mem_head_reg;
    logic [AW-1:0]  mem_head_next;
    logic [AW-1:0]  mem_tail_reg;
    logic [AW-1:0]  mem_tail_next;
    logic           mem_we;
    logic           mem_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(WORD_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    // words beyond the window live in memory
    assign mem_we  = ctrl.push && (count_reg >= CW'(2));
    assign mem_pop = ctrl.pop && (count_reg >= CW'(3));

    assign mem_head_next = mem_pop ? ptr_inc(mem_head_reg) : mem_head_reg;
    assign mem_tail_next = mem_we ? ptr_inc(mem_tail_reg) : mem_tail_reg;

    always_comb
    begin
        if (ctrl.push)
            count_next = count_reg + 1'b1;
        else if (ctrl.pop)
            count_next = count_reg - 1'b1;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            mem_head_reg <= '0;
            mem_tail_reg <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            mem_head_reg <= mem_head_next;
            mem_tail_reg <= mem_tail_next;
        end
    end

    // window: fill from load while short, shift up on pop
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            if (count_reg == CW'(0))
                win0_reg <= load_word;
            else if (count_reg == CW'(1))
                win1_reg <= load_word;
        end
        else if (ctrl.pop)
        begin
            win0_reg <= win1_reg;
            win1_reg <= rd_data_reg;
        end
    end

    // prefetch the next memory head; bypass a write to that slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_tail_reg] <= load_word;
        if (mem_we && (mem_tail_reg == mem_head_next))
            rd_data_reg <= load_word;
        else
            rd_data_reg <= mem[mem_head_next];
    end

    assign head_word  = win0_reg;
    assign next_word  = (count_reg >= CW'(2)) ? win1_reg : '0;
    assign word_count = count_reg;

endmodule

### rtl/core/bfr_field_logic.sv
// ----------------------------------------------------------------------------
// bfr_field_logic
// Decodes one item against the window: extracts the field, works out the
// bits to consume, the queue moves and the status.
// ----------------------------------------------------------------------------
module bfr_field_logic #(
    parameter int WORD_DEPTH = 16
) (
    input  logic [2:0]                        kind,
    input  logic [5:0]                        bit_count,
    input  bfr_pkg::word_t                    head_word,
    input  bfr_pkg::word_t                    next_word,
    input  logic [$clog2(WORD_DEPTH+1)-1:0]   word_count,
    input  logic [4:0]                        bit_offset,
    output bfr_pkg::queue_ctrl_t              ctrl,
    output bfr_pkg::word_t                    field_value,
    output logic [1:0]                        status,
    output logic [4:0]                        offset_next,
    output logic [5:0]                        consume_bits,
    output logic [9:0]                        bits_available
);
    import bfr_pkg::*;

    localparam int CW = $clog2(WORD_DEPTH + 1);
    localparam int VW = CW + 5;
    localparam int LW = (VW > 10) ? VW : 10;

    logic [5:0]     n_sat;
    logic [VW-1:0]  avail;
    logic [63:0]    joined;
    word_t          peek_value;
    logic [2:0]     align_drop;
    logic [5:0]     pos;
    logic           push;
    logic [CW-1:0]  count_next;
    logic [LW-1:0]  avail_next;

    assign n_sat      = (bit_count > MAX_FIELD) ? MAX_FIELD : bit_count;
    assign avail      = {word_count, 5'b00000} - VW'(bit_offset);
    assign joined     = {head_word, next_word} << bit_offset;
    assign peek_value = joined[63:32] >> (MAX_FIELD - n_sat);
    // bits up to the next byte boundary
    assign align_drop = 3'd0 - bit_offset[2:0];

    always_comb
    begin
        status       = ST_OK;
        field_value  = '0;
        consume_bits = '0;
        push         = 1'b0;
        case (kind) inside
            KIND_LOAD:
            begin
                if (word_count >= CW'(WORD_DEPTH))
                    status = ST_FULL;
                else
                    push = 1'b1;
            end
            KIND_GET, KIND_PEEK, KIND_SKIP:
            begin
                if (VW'(n_sat) > avail)
                    status = ST_STARVED;
                else
                begin
                    if (kind != KIND_SKIP)
                        field_value = peek_value;
                    if (kind != KIND_PEEK)
                        consume_bits = n_sat;
                end
            end
            KIND_ALIGN:
            begin
                if (word_count != CW'(0))
                    consume_bits = {3'b000, align_drop};
            end
            default:
            begin
            end
        endcase
    end

    // at most one word leaves per beat
    assign pos         = {1'b0, bit_offset} + consume_bits;
    assign offset_next = pos[4:0];
    assign ctrl.push   = push;
    assign ctrl.pop    = pos[5];

    always_comb
    begin
        if (push)
            count_next = word_count + 1'b1;
        else if (pos[5])
            count_next = word_count - 1'b1;
        else
            count_next = word_count;
    end

    assign avail_next     = LW'({count_next, 5'b00000}) - LW'(offset_next);
    assign bits_available = avail_next[9:0];

endmodule

### rtl/core/bitstream_field_reader_unit.sv
// ----------------------------------------------------------------------------
// bitstream_field_reader_unit
// MSB-first bit reader over a queue of 32-bit stream words: load, get, peek,
// skip and byte align items, one result beat per item.
// ----------------------------------------------------------------------------
// Pipeline: input register, then one pass through window shift, field
//   extract and status into the result register.
// Throughput: 1 item per cycle while out_stall does not hold the result
//   register; the queue refills its window from the prefetched memory head
//   in the same cycle a word leaves.
// Reset: rst_n clears the queue pointers, word count, bit offset, consumed
//   total and both valid flags; the word memory is left as is.
// ----------------------------------------------------------------------------
module bitstream_field_reader_unit #(
    parameter int WORD_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           kind,
    input  logic [5:0]           bit_count,
    input  bfr_pkg::word_t       stream_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bfr_pkg::word_t       field_value,
    output logic [1:0]           status,
    output logic [31:0]          bits_consumed,
    output logic [9:0]           bits_available
);
    import bfr_pkg::*;

    localparam int CW = $clog2(WORD_DEPTH + 1);

    // input stage
    logic           s1_valid_reg;
    logic           s1_valid_next;
    logic [2:0]     s1_kind_reg;
    logic [5:0]     s1_count_reg;
    word_t          s1_word_reg;

    // stream state
    logic [4:0]     offset_reg;
    logic [31:0]    consumed_reg;
    logic [31:0]    consumed_next;

    // result stage
    logic           out_valid_reg;
    logic           out_valid_next;
    word_t          field_reg;
    logic [1:0]     status_reg;
    logic [31:0]    bits_consumed_reg;
    logic [9:0]     avail_reg;

    logic           out_busy;
    logic           in_fire;
    logic           exec_fire;

    queue_ctrl_t    raw_ctrl;
    queue_ctrl_t    queue_ctrl;
    word_t          head_word;
    word_t          next_word;
    logic [CW-1:0]  word_count;
    word_t          calc_value;
    logic [1:0]     calc_status;
    logic [4:0]     calc_offset;
    logic [5:0]     calc_consume;
    logic [9:0]     calc_avail;

    // Hold the result register while the sink stalls it; the input stage
    // advances whenever the result register is free or draining this cycle.
    assign out_busy  = out_valid_reg && out_stall;
    assign exec_fire = s1_valid_reg && !out_busy;
    assign in_stall  = s1_valid_reg && out_busy;
    assign in_fire   = in_valid && !in_stall;

    always_comb
    begin
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (exec_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        if (exec_fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the input beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg  <= kind;
            s1_count_reg <= bit_count;
            s1_word_reg  <= stream_word;
        end
    end

    bfr_field_logic #(
        .WORD_DEPTH (WORD_DEPTH)
    ) u_field (
        .kind           (s1_kind_reg),
        .bit_count      (s1_count_reg),
        .head_word      (head_word),
        .next_word      (next_word),
        .word_count     (word_count),
        .bit_offset     (offset_reg),
        .ctrl           (raw_ctrl),
        .field_value    (calc_value),
        .status         (calc_status),
        .offset_next    (calc_offset),
        .consume_bits   (calc_consume),
        .bits_available (calc_avail)
    );

    // queue moves only when the item actually executes
    assign queue_ctrl.push = raw_ctrl.push && exec_fire;
    assign queue_ctrl.pop  = raw_ctrl.pop && exec_fire;

    bfr_word_queue #(
        .WORD_DEPTH (WORD_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (queue_ctrl),
        .load_word  (s1_word_reg),
        .head_word  (head_word),
        .next_word  (next_word),
        .word_count (word_count)
    );

    // running total wraps at 2^32
    assign consumed_next = consumed_reg + 32'(calc_consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            consumed_reg <= '0;
        end
        else if (exec_fire)
        begin
            offset_reg   <= calc_offset;
            consumed_reg <= consumed_next;
        end
    end

    // load the result beat
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            field_reg         <= calc_value;
            status_reg        <= calc_status;
            bits_consumed_reg <= consumed_next;
            avail_reg         <= calc_avail;
        end
    end

    assign out_valid      = out_valid_reg;
    assign field_value    = field_reg;
    assign status         = status_reg;
    assign bits_consumed  = bits_consumed_reg;
    assign bits_available = avail_reg;

endmodule
